// File: hdl/nsf_pkg.sv
// ----------------------------------------------------------------------------
// nsf_pkg: shared types and constants of the NMEA sentence framer
// Holds the character constants, the header pattern table and the record
// that the front end hands to the back end for each received byte.
// ----------------------------------------------------------------------------
package nsf_pkg;

  localparam int NUM_TYPES = 4;
  localparam int PAT_LEN   = 4;
  localparam int QDEPTH    = 2;

  localparam logic [7:0] MAX_BODY_LEN = 8'd128;

  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_A      = 8'h41;  // 'A'
  localparam logic [7:0] HEX_ALPHA = 8'd10;

  // Header patterns in type order: "RMC,", "GGA,", "GSA,", "GSV,".
  localparam logic [7:0] PATTERN [NUM_TYPES][PAT_LEN] = '{
    '{8'h52, 8'h4D, 8'h43, 8'h2C},
    '{8'h47, 8'h47, 8'h41, 8'h2C},
    '{8'h47, 8'h53, 8'h41, 8'h2C},
    '{8'h47, 8'h53, 8'h56, 8'h2C}
  };

  typedef enum logic [1:0] {
    CAUSE_MATCH    = 2'd0,
    CAUSE_MISMATCH = 2'd1,
    CAUSE_OVERFLOW = 2'd2
  } end_cause_t;

  // Classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0]                            data;
    logic                                  is_star;
    logic                                  is_dollar;
    logic [7:0]                            hex_val;
    logic [NUM_TYPES-1:0][PAT_LEN-1:0]     hit;
  } byte_class_t;

endpackage

// File: hdl/nsf_front.sv
// ----------------------------------------------------------------------------
// nsf_front: byte classifier and queue
// Accepts received bytes, precomputes the character compares and the hex
// digit value, and holds the results in a short queue for the back end.
// ----------------------------------------------------------------------------
module nsf_front
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_byte,
  output logic        q_valid,
  output byte_class_t q_item,
  input  logic        q_pop
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  byte_class_t    mem_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  byte_class_t    cls;
  logic           push;

  always_comb begin
    cls.data      = in_byte;
    cls.is_star   = (in_byte == CH_STAR);
    cls.is_dollar = (in_byte == CH_DOLLAR);
    if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
      cls.hex_val = in_byte - CH_ZERO;
    end else begin
      // Anything else decodes as a letter digit, wrapping modulo 256.
      cls.hex_val = in_byte - CH_A + HEX_ALPHA;
    end
    for (int i = 0; i < NUM_TYPES; i++) begin
      for (int p = 0; p < PAT_LEN; p++) begin
        cls.hit[i][p] = (in_byte == PATTERN[i][p]);
      end
    end
  end

  assign in_tready = (count_r != CW'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: hdl/nsf_back.sv
// ----------------------------------------------------------------------------
// nsf_back: sentence framing engine and result register
// Applies one classified byte per cycle, when no result stalls, to the
// checksum, header matcher and capture state; holds the result until taken.
// ----------------------------------------------------------------------------
module nsf_back
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  byte_class_t q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic [2:0]  prog_r [NUM_TYPES];
  logic [2:0]  prog_nxt [NUM_TYPES];
  logic        capt_r, capt_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        sum_r, sum_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  rxsum_r, rxsum_nxt;

  logic        ov_r;
  logic        o_cap_r, o_cap_nxt;
  logic [1:0]  o_type_r, o_type_nxt;
  logic [6:0]  o_idx_r, o_idx_nxt;
  logic [7:0]  o_val_r, o_val_nxt;
  logic        o_end_r, o_end_nxt;
  end_cause_t  o_cause_r, o_cause_nxt;
  logic        o_ok_r, o_ok_nxt;

  logic        fire;

  assign fire  = q_valid && (!ov_r || out_tready);
  assign q_pop = fire;

  always_comb begin
    logic       done;
    logic       checked;
    logic       match;
    logic [2:0] p;
    logic [7:0] c;

    c           = q_item.data;
    done        = 1'b0;
    checked     = 1'b0;
    match       = 1'b0;
    p           = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      prog_nxt[i] = prog_r[i];
    end
    capt_nxt    = capt_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    phase_nxt   = phase_r;
    rxsum_nxt   = rxsum_r;
    o_cap_nxt   = 1'b0;
    o_type_nxt  = '0;
    o_idx_nxt   = '0;
    o_val_nxt   = '0;
    o_end_nxt   = 1'b0;
    o_cause_nxt = CAUSE_MATCH;
    o_ok_nxt    = 1'b0;

    // Checksum window: a star closes it before the XOR, a dollar reopens it.
    sum_nxt = q_item.is_star ? 1'b0 : sum_r;
    xor_nxt = xor_r;
    if (q_item.is_dollar) begin
      sum_nxt   = 1'b1;
      xor_nxt   = '0;
      phase_nxt = '0;
    end else if (sum_nxt) begin
      xor_nxt = xor_r ^ c;
    end

    if (!capt_r) begin
      // The first matcher to complete wins and later ones keep their progress.
      for (int i = 0; i < NUM_TYPES; i++) begin
        if (!done) begin
          p = prog_r[i];
          if (!p[2] && q_item.hit[i][p[1:0]]) begin
            prog_nxt[i] = p + 3'd1;
            if (p == 3'(PAT_LEN - 1)) begin
              type_nxt = 2'(i);
              capt_nxt = 1'b1;
              len_nxt  = '0;
              done     = 1'b1;
            end
          end else begin
            prog_nxt[i] = '0;
          end
        end
      end
    end else begin
      if (len_r == '0) begin
        phase_nxt = '0;
        rxsum_nxt = '0;
      end
      if (q_item.is_star) begin
        rxsum_nxt = '0;
        phase_nxt = 2'd1;
      end else if (phase_nxt != '0) begin
        rxsum_nxt = rxsum_nxt | q_item.hex_val;
        if (phase_nxt == 2'd1) begin
          rxsum_nxt = {rxsum_nxt[3:0], 4'h0};
          phase_nxt = 2'd2;
        end else begin
          checked   = 1'b1;
          phase_nxt = 2'd3;
        end
      end
      match = (rxsum_nxt == xor_nxt);

      o_type_nxt = type_r;
      if (!checked) begin
        o_cap_nxt = 1'b1;
        o_idx_nxt = len_r[6:0];
        o_val_nxt = c;
      end
      len_nxt = len_r + 8'd1;
      if (checked) begin
        o_end_nxt   = 1'b1;
        o_cause_nxt = match ? CAUSE_MATCH : CAUSE_MISMATCH;
        o_ok_nxt    = match;
      end else if (len_nxt >= MAX_BODY_LEN) begin
        o_end_nxt   = 1'b1;
        o_cause_nxt = CAUSE_OVERFLOW;
      end
      if (o_end_nxt) begin
        capt_nxt = 1'b0;
        for (int i = 0; i < NUM_TYPES; i++) begin
          prog_nxt[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        prog_r[i] <= '0;
      end
      capt_r  <= 1'b0;
      type_r  <= '0;
      len_r   <= '0;
      sum_r   <= 1'b0;
      xor_r   <= '0;
      phase_r <= '0;
      rxsum_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (fire) begin
        for (int i = 0; i < NUM_TYPES; i++) begin
          prog_r[i] <= prog_nxt[i];
        end
        capt_r  <= capt_nxt;
        type_r  <= type_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        xor_r   <= xor_nxt;
        phase_r <= phase_nxt;
        rxsum_r <= rxsum_nxt;
        ov_r    <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_cap_r   <= o_cap_nxt;
      o_type_r  <= o_type_nxt;
      o_idx_r   <= o_idx_nxt;
      o_val_r   <= o_val_nxt;
      o_end_r   <= o_end_nxt;
      o_cause_r <= o_cause_nxt;
      o_ok_r    <= o_ok_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, o_ok_r, o_cause_r, o_val_r, o_idx_r};
  assign out_tuser  = {o_type_r, o_cap_r};
  assign out_tlast  = o_end_r;

endmodule

// File: hdl/nmea_sentence_framer_top.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_top: NMEA 0183 sentence framer with checksum check
// Takes one received byte per beat and returns one result beat per byte.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one received byte per beat. The out_ channel
//   returns exactly one beat per input byte, in order. A beat with
//   out_tuser[0] set carries a sentence body byte with its index; out_tlast
//   marks the beat on which capture of an RMC, GGA, GSA or GSV sentence
//   ends, with the end cause and the checksum-good flag in out_tdata.
//   An accepted byte is written into the queue, then applied by the
//   framing engine and held in the result register that drives its beat.
//   Throughput: one byte per cycle while the receiver is ready; the
//   back-end per-byte state update is combinational compares and an XOR.
//   A two-entry queue sits between the classifier and the framing engine,
//   and the result register is separate, so input is still taken while a
//   result waits. When the receiver stalls, the queue fills after two more
//   bytes and in_tready drops until results drain.
//   Reset (rst_n low, synchronous) empties the queue and the result
//   register and clears checksum, matcher and capture state.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_top
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [6:0] byte_index, [14:7] byte_value,
                                  // [16:15] end_cause, [17] sentence_ok
  output logic [2:0]  out_tuser,  // [0] capture_valid, [2:1] sentence_type
  output logic        out_tlast   // sentence_end
);

  logic        q_valid;
  byte_class_t q_item;
  logic        q_pop;

  nsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  nsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hdl/nsf_checker.sv
// ----------------------------------------------------------------------------
// nsf_checker: port-level checks of the sentence framer
// Watches the result channel for stall behavior, reset and field consistency.
// ----------------------------------------------------------------------------
module nsf_checker
  import nsf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // A result that is not taken stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Index and value are only set on captured body bytes.
  a_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[14:0] == 15'd0)
    else $error("body fields set without capture");

  // End cause and the good flag only appear on the closing beat.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[17:15] == 3'd0)
    else $error("end fields set without sentence end");

  // A good sentence closes on its checksum digit, which is not body.
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tlast && !out_tuser[0]
      && out_tdata[16:15] == CAUSE_MATCH)
    else $error("sentence good flag on a wrong beat");

endmodule

bind nmea_sentence_framer_top nsf_checker u_nsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
